/* hw/rtl/assert_macros.svh */
// Assertion macros used by the RTL of the path generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* hw/rtl/cspg_pkg.sv */
package cspg_pkg;

    localparam int INDEX_BITS = 16;
    localparam int ANGLE_BITS = 16;
    localparam int ANGLE_SHIFT = 24 - ANGLE_BITS;
    localparam int QUARTER = 1 << (ANGLE_BITS - 2);
    localparam int DIV_LONG_BITS = 48;
    localparam int DIV_SHORT_BITS = 32;
    localparam int DIVISOR_BITS = 16;

    localparam logic [32:0] PI_Q31 = 33'd6746518852;
    localparam logic [30:0] Q30_ONE = 31'h4000_0000;

    localparam logic [2:0] CFG_POINT_COUNT = 3'd0;
    localparam logic [2:0] CFG_FREQ_START  = 3'd1;
    localparam logic [2:0] CFG_FREQ_END    = 3'd2;
    localparam logic [2:0] CFG_AMPLITUDE   = 3'd3;
    localparam logic [2:0] CFG_X_SCALE     = 3'd4;
    localparam logic [2:0] CFG_OFFSET_X    = 3'd5;
    localparam logic [2:0] CFG_OFFSET_Y    = 3'd6;
    localparam logic [2:0] CFG_OFFSET_Z    = 3'd7;

    localparam logic [2:0] POLY_LAST = 3'd4;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_DIV_STEP,
        OP_SET_STEP,
        OP_MUL_F,
        OP_SET_F,
        OP_MUL_FI,
        OP_DIV_PHASE,
        OP_SET_ANGLE,
        OP_MUL_XR,
        OP_SET_X,
        OP_MUL_X2,
        OP_SET_X2,
        OP_MUL_T,
        OP_DIV_T,
        OP_SET_T,
        OP_MUL_S,
        OP_SET_S,
        OP_MUL_AMP,
        OP_SET_TERM,
        OP_MUL_XS,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        logic   load;
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic step_needed;
        logic div_busy;
        logic k_last;
    } dp_stat_t;

    // The divisors of the nested sine polynomial (110, 72, 42, 20 and 6, innermost
    // term first) are applied as ceil(2^L / k) followed by a right shift of L.
    // Each L is large enough for the quotient to be exact for any 32-bit dividend.
    function automatic logic [32:0] poly_magic(input logic [2:0] idx);
        logic [32:0] m;
        case (idx)
            3'd0:    m = 33'd4997780127;
            3'd1:    m = 33'd7635497416;
            3'd2:    m = 33'd6544712071;
            3'd3:    m = 33'd6871947674;
            default: m = 33'd5726623062;
        endcase
        return m;
    endfunction

    function automatic logic [5:0] poly_shift(input logic [2:0] idx);
        logic [5:0] l;
        case (idx)
            3'd0:    l = 6'd39;
            3'd1:    l = 6'd39;
            3'd2:    l = 6'd38;
            3'd3:    l = 6'd37;
            default: l = 6'd35;
        endcase
        return l;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [48:0] v);
        logic [31:0] r;
        if (v > 49'sd2147483647)
            r = 32'h7FFF_FFFF;
        else if (v < -49'sd2147483648)
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

/* hw/rtl/cspg_div.sv */
module cspg_div import cspg_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     long_mode,
    input  logic [DIV_LONG_BITS-1:0] dividend,
    input  logic [DIVISOR_BITS-1:0]  divisor,
    output logic                     busy,
    output logic [DIV_LONG_BITS-1:0] quotient
);

    logic                     busy_reg;
    logic [5:0]               cnt_reg;
    logic [DIVISOR_BITS-1:0]  rem_reg;
    logic [DIVISOR_BITS-1:0]  dvs_reg;
    logic [DIV_LONG_BITS-1:0] dq_reg;
    logic [DIVISOR_BITS:0]    trial;
    logic                     fits;

    // One restoring step a cycle; dividend bits leave at the top of dq_reg
    // while quotient bits enter at the bottom.
    assign trial = {rem_reg, dq_reg[DIV_LONG_BITS-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= long_mode ? 6'(DIV_LONG_BITS - 1) : 6'(DIV_SHORT_BITS - 1);
        end
        else if (busy_reg) begin
            if (cnt_reg == '0)
                busy_reg <= 1'b0;
            else
                cnt_reg <= cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge clk) begin
        if (start) begin
            rem_reg <= '0;
            dvs_reg <= divisor;
            dq_reg  <= long_mode ? dividend
                                 : {dividend[DIV_SHORT_BITS-1:0],
                                    (DIV_LONG_BITS - DIV_SHORT_BITS)'(0)};
        end
        else if (busy_reg) begin
            rem_reg <= fits ? DIVISOR_BITS'(trial - {1'b0, dvs_reg})
                            : trial[DIVISOR_BITS-1:0];
            dq_reg  <= {dq_reg[DIV_LONG_BITS-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign quotient = dq_reg;

endmodule

/* hw/rtl/cspg_dp.sv */
module cspg_dp import cspg_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_cmd_t               cmd,
    output dp_stat_t              status,
    input  logic                  kind,
    input  logic                  plane,
    input  logic                  cfg_write,
    input  logic [2:0]            cfg_index,
    input  logic [31:0]           cfg_data,
    output logic [INDEX_BITS-1:0] point_index,
    output logic [31:0]           pos_x,
    output logic [31:0]           pos_y,
    output logic [31:0]           pos_z,
    output logic                  last_point
);

    logic [15:0] point_count_reg;
    logic [23:0] freq_start_reg;
    logic [23:0] freq_end_reg;
    logic [31:0] amplitude_reg;
    logic [31:0] x_scale_reg;
    logic [31:0] offset_x_reg;
    logic [31:0] offset_y_reg;
    logic [31:0] offset_z_reg;

    logic [INDEX_BITS-1:0] next_index_reg;
    logic [31:0]           step_reg;
    logic [2:0]            k_idx_reg;

    logic                  kind_reg;
    logic                  plane_reg;
    logic [INDEX_BITS-1:0] i_reg;
    logic [31:0]           f_reg;
    logic [1:0]            quad_reg;
    logic [ANGLE_BITS-2:0] r_reg;
    logic [30:0]           x_reg;
    logic [31:0]           x2_reg;
    logic [30:0]           t_reg;
    logic [30:0]           s_reg;
    logic signed [32:0]    term_reg;
    logic [64:0]           prod_reg;

    logic [INDEX_BITS-1:0] point_index_reg;
    logic [31:0]           pos_x_reg;
    logic [31:0]           pos_y_reg;
    logic [31:0]           pos_z_reg;
    logic                  last_reg;

    logic [15:0]              n_eff;
    logic [32:0]              mul_a;
    logic [31:0]              mul_b;
    logic                     is_mul;
    logic [31:0]              abs_amp;
    logic [31:0]              abs_xs;
    logic                     div_start;
    logic                     div_long;
    logic [DIV_LONG_BITS-1:0] div_dividend;
    logic [DIVISOR_BITS-1:0]  div_divisor;
    logic                     div_busy;
    logic [DIV_LONG_BITS-1:0] quot;

    logic [ANGLE_BITS-1:0] angle;
    logic [ANGLE_BITS-3:0] r_raw;
    logic [23:0]           fdiff;
    logic [61:0]           mag_sum;
    logic [31:0]           mag;
    logic signed [48:0]    px_mag;
    logic signed [48:0]    px_sum;
    logic signed [48:0]    term_ext;
    logic signed [48:0]    ty_sum;
    logic signed [48:0]    tz_sum;
    logic [INDEX_BITS:0]   i_plus;
    logic [30:0]           s_raw;
    logic [64:0]           recip_q;

    assign n_eff   = (point_count_reg == '0) ? 16'd1 : point_count_reg;
    assign abs_amp = amplitude_reg[31] ? 32'(-amplitude_reg) : amplitude_reg;
    assign abs_xs  = x_scale_reg[31] ? 32'(-x_scale_reg) : x_scale_reg;
    assign fdiff   = freq_end_reg - freq_start_reg;

    assign status.step_needed = !kind_reg && (freq_end_reg > freq_start_reg)
                                && (n_eff >= 16'd2);
    assign status.div_busy    = div_busy;
    assign status.k_last      = (k_idx_reg == POLY_LAST);

    // The one shared multiplier: operands chosen by the current operation.
    // The polynomial division multiplies by the reciprocal of its constant.
    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        is_mul = 1'b1;
        case (cmd.op)
            OP_MUL_F:   begin mul_a = 33'(step_reg);  mul_b = 32'(i_reg);  end
            OP_MUL_FI:  begin mul_a = 33'(f_reg);     mul_b = 32'(i_reg);  end
            OP_MUL_XR:  begin mul_a = PI_Q31;         mul_b = 32'(r_reg);  end
            OP_MUL_X2:  begin mul_a = 33'(x_reg);     mul_b = 32'(x_reg);  end
            OP_MUL_T:   begin mul_a = 33'(x2_reg);    mul_b = 32'(t_reg);  end
            OP_DIV_T:   begin mul_a = poly_magic(k_idx_reg); mul_b = prod_reg[61:30]; end
            OP_MUL_S:   begin mul_a = 33'(x_reg);     mul_b = 32'(t_reg);  end
            OP_MUL_AMP: begin mul_a = 33'(abs_amp);   mul_b = 32'(s_reg);  end
            OP_MUL_XS:  begin mul_a = 33'(i_reg);     mul_b = abs_xs;      end
            default:    is_mul = 1'b0;
        endcase
    end

    always_comb begin
        div_start    = 1'b1;
        div_long     = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        case (cmd.op)
            OP_DIV_STEP: begin
                div_dividend = DIV_LONG_BITS'({fdiff, 8'h00});
                div_divisor  = n_eff - 16'd1;
            end
            OP_DIV_PHASE: begin
                div_long     = 1'b1;
                div_dividend = prod_reg[DIV_LONG_BITS-1:0];
                div_divisor  = n_eff;
            end
            default:  div_start = 1'b0;
        endcase
    end

    cspg_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .long_mode (div_long),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .quotient  (quot)
    );

    assign angle   = quot[ANGLE_SHIFT +: ANGLE_BITS];
    assign r_raw   = angle[ANGLE_BITS-3:0];
    assign mag_sum = prod_reg[61:0] + 62'h2000_0000;
    assign mag     = mag_sum[61:30];
    assign s_raw   = prod_reg[60:30];
    assign recip_q = prod_reg >> poly_shift(k_idx_reg);

    assign px_mag   = $signed({2'b00, prod_reg[46:0]});
    assign px_sum   = (x_scale_reg[31] ? -px_mag : px_mag)
                      + $signed({{17{offset_x_reg[31]}}, offset_x_reg});
    assign term_ext = $signed({{16{term_reg[32]}}, term_reg});
    assign ty_sum   = term_ext + $signed({{17{offset_y_reg[31]}}, offset_y_reg});
    assign tz_sum   = term_ext + $signed({{17{offset_z_reg[31]}}, offset_z_reg});
    assign i_plus   = {1'b0, i_reg} + (INDEX_BITS + 1)'(1);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            point_count_reg <= 16'd100;
            freq_start_reg  <= 24'd65536;
            freq_end_reg    <= 24'd65536;
            amplitude_reg   <= 32'd65536;
            x_scale_reg     <= 32'd65536;
            offset_x_reg    <= '0;
            offset_y_reg    <= '0;
            offset_z_reg    <= '0;
            next_index_reg  <= '0;
            step_reg        <= '0;
            k_idx_reg       <= '0;
        end
        else begin
            if (cfg_write) begin
                case (cfg_index)
                    CFG_POINT_COUNT: point_count_reg <= cfg_data[15:0];
                    CFG_FREQ_START:  freq_start_reg  <= cfg_data[23:0];
                    CFG_FREQ_END:    freq_end_reg    <= cfg_data[23:0];
                    CFG_AMPLITUDE:   amplitude_reg   <= cfg_data;
                    CFG_X_SCALE:     x_scale_reg     <= cfg_data;
                    CFG_OFFSET_X:    offset_x_reg    <= cfg_data;
                    CFG_OFFSET_Y:    offset_y_reg    <= cfg_data;
                    CFG_OFFSET_Z:    offset_z_reg    <= cfg_data;
                    default:         ;
                endcase
            end
            if (cmd.load && !kind)
                step_reg <= '0;
            case (cmd.op)
                OP_SET_STEP: step_reg  <= quot[31:0];
                OP_SET_X2:   k_idx_reg <= '0;
                OP_SET_T:    k_idx_reg <= k_idx_reg + 3'd1;
                OP_OUT:      next_index_reg <= (i_plus >= {1'b0, n_eff})
                                               ? '0 : i_plus[INDEX_BITS-1:0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.load) begin
            kind_reg  <= kind;
            plane_reg <= plane;
            if (!kind)
                i_reg <= '0;
            else
                i_reg <= (next_index_reg >= n_eff) ? '0 : next_index_reg;
        end
        if (is_mul)
            prod_reg <= 65'(mul_a) * 65'(mul_b);
        case (cmd.op)
            OP_SET_F: f_reg <= {freq_start_reg, 8'h00} + prod_reg[31:0];
            OP_SET_ANGLE: begin
                quad_reg <= angle[ANGLE_BITS-1 -: 2];
                r_reg    <= angle[ANGLE_BITS-2] ? (ANGLE_BITS-1)'(QUARTER) - {1'b0, r_raw}
                                                : {1'b0, r_raw};
            end
            OP_SET_X:  x_reg  <= prod_reg[ANGLE_BITS +: 31];
            OP_SET_X2: begin
                x2_reg <= prod_reg[61:30];
                t_reg  <= Q30_ONE;
            end
            OP_SET_T:  t_reg  <= Q30_ONE - recip_q[30:0];
            OP_SET_S:  s_reg  <= (s_raw > Q30_ONE) ? Q30_ONE : s_raw;
            OP_SET_TERM: begin
                if (quad_reg[1] ^ amplitude_reg[31])
                    term_reg <= -$signed({1'b0, mag});
                else
                    term_reg <= $signed({1'b0, mag});
            end
            OP_OUT: begin
                point_index_reg <= i_reg;
                last_reg        <= (i_reg == n_eff - 16'd1);
                pos_x_reg       <= sat32(px_sum);
                if (plane_reg) begin
                    pos_y_reg <= sat32(ty_sum);
                    pos_z_reg <= offset_z_reg;
                end
                else begin
                    pos_y_reg <= offset_y_reg;
                    pos_z_reg <= sat32(tz_sum);
                end
            end
            default: ;
        endcase
    end

    assign point_index = point_index_reg;
    assign pos_x       = pos_x_reg;
    assign pos_y       = pos_y_reg;
    assign pos_z       = pos_z_reg;
    assign last_point  = last_reg;

endmodule

/* hw/rtl/cspg_ctrl.sv */
`include "assert_macros.svh"

module cspg_ctrl import cspg_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    input  dp_stat_t status,
    output dp_cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_CHECK, S_STEP_DIV, S_STEP_WAIT, S_SET_STEP,
        S_MUL_F, S_SET_F, S_MUL_FI, S_DIV_PH, S_PH_WAIT, S_SET_ANG,
        S_MUL_XR, S_SET_X, S_MUL_X2, S_SET_X2, S_MUL_T, S_DIV_T,
        S_SET_T, S_MUL_S, S_SET_S, S_MUL_AMP, S_SET_TERM,
        S_MUL_XS, S_OUT_WAIT, S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    dp_op_t op_reg;
    logic   stall_reg;
    logic   out_valid_reg;
    logic   load;

    // Each working state issues one datapath operation, registered with the state; idle, check and wait issue none.
    function automatic dp_op_t op_of(input state_t s);
        dp_op_t o;
        case (s)
            S_STEP_DIV: o = OP_DIV_STEP;
            S_SET_STEP: o = OP_SET_STEP;
            S_MUL_F:    o = OP_MUL_F;
            S_SET_F:    o = OP_SET_F;
            S_MUL_FI:   o = OP_MUL_FI;
            S_DIV_PH:   o = OP_DIV_PHASE;
            S_SET_ANG:  o = OP_SET_ANGLE;
            S_MUL_XR:   o = OP_MUL_XR;
            S_SET_X:    o = OP_SET_X;
            S_MUL_X2:   o = OP_MUL_X2;
            S_SET_X2:   o = OP_SET_X2;
            S_MUL_T:    o = OP_MUL_T;
            S_DIV_T:    o = OP_DIV_T;
            S_SET_T:    o = OP_SET_T;
            S_MUL_S:    o = OP_MUL_S;
            S_SET_S:    o = OP_SET_S;
            S_MUL_AMP:  o = OP_MUL_AMP;
            S_SET_TERM: o = OP_SET_TERM;
            S_MUL_XS:   o = OP_MUL_XS;
            S_OUT:      o = OP_OUT;
            default:    o = OP_NONE;
        endcase
        return o;
    endfunction

    assign load = in_valid && !stall_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:      if (load) state_next = S_CHECK;
            S_CHECK:     state_next = status.step_needed ? S_STEP_DIV : S_MUL_F;
            S_STEP_DIV:  state_next = S_STEP_WAIT;
            S_STEP_WAIT: if (!status.div_busy) state_next = S_SET_STEP;
            S_SET_STEP:  state_next = S_MUL_F;
            S_MUL_F:     state_next = S_SET_F;
            S_SET_F:     state_next = S_MUL_FI;
            S_MUL_FI:    state_next = S_DIV_PH;
            S_DIV_PH:    state_next = S_PH_WAIT;
            S_PH_WAIT:   if (!status.div_busy) state_next = S_SET_ANG;
            S_SET_ANG:   state_next = S_MUL_XR;
            S_MUL_XR:    state_next = S_SET_X;
            S_SET_X:     state_next = S_MUL_X2;
            S_MUL_X2:    state_next = S_SET_X2;
            S_SET_X2:    state_next = S_MUL_T;
            S_MUL_T:     state_next = S_DIV_T;
            S_DIV_T:     state_next = S_SET_T;
            S_SET_T:     state_next = status.k_last ? S_MUL_S : S_MUL_T;
            S_MUL_S:     state_next = S_SET_S;
            S_SET_S:     state_next = S_MUL_AMP;
            S_MUL_AMP:   state_next = S_SET_TERM;
            S_SET_TERM:  state_next = S_MUL_XS;
            S_MUL_XS:    state_next = S_OUT_WAIT;
            S_OUT_WAIT:  if (!out_valid_reg || !out_stall) state_next = S_OUT;
            S_OUT:       state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_NONE;
            stall_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg <= state_next;
            op_reg    <= op_of(state_next);
            stall_reg <= (state_next != S_IDLE);
            if (state_reg == S_OUT)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign cmd.load  = load;
    assign cmd.op    = op_reg;
    assign in_stall  = stall_reg;
    assign out_valid = out_valid_reg;

    `ASSERT_NEXT(a_load_stalls, clk, rst_n, load, stall_reg)
    `ASSERT_IMPL(a_out_slot_free, clk, rst_n, state_reg == S_OUT, !out_valid_reg)
    `ASSERT_IMPL(a_quot_ready, clk, rst_n, state_reg == S_SET_ANG || state_reg == S_SET_STEP,
                 !status.div_busy)

endmodule

/* hw/rtl/chirp_sine_path_generator.sv */
// Chirp sine path generator: each request (kind 0 restarts at point zero, kind 1
// steps to the next point, wrapping after the last) yields one Q16.16 point whose
// sine axis follows a linearly swept frequency. Requests are handled one at a
// time; the input is released in the cycle in which the result appears. The
// processing time is set by the shared one-bit-a-cycle divider, which divides by
// the point count for the phase (48 steps) and by the point count minus one for
// the sweep step (32 steps), and by a chain of steps on one shared multiplier,
// which also divides by the constants of the sine polynomial through their
// reciprocals. A finished point waits in the output register while the next
// request is already being worked on; if it has still not been taken when the
// next point is ready, the block waits. Configuration registers are written
// through the cfg port, which is always ready, and must be written only while no
// request is outstanding.
module chirp_sine_path_generator import cspg_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  kind,
    input  logic                  plane,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [INDEX_BITS-1:0] point_index,
    output logic [31:0]           pos_x,
    output logic [31:0]           pos_y,
    output logic [31:0]           pos_z,
    output logic                  last_point,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [2:0]            cfg_index,
    input  logic [31:0]           cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t status;

    assign cfg_ready = 1'b1;

    cspg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    cspg_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .kind        (kind),
        .plane       (plane),
        .cfg_write   (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .point_index (point_index),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .last_point  (last_point)
    );

endmodule
